### rtl/core/ppi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppi_pkg
// Shared types for the pixel palette indexer: request and result payloads
// and the scan sequencer states.
// ---------------------------------------------------------------------------
package ppi_pkg;

	localparam int unsigned COLOR_W = 24;

	// one pixel request
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       first_pixel;
		logic       last_pixel;
	} pix_in_t;

	// one pixel result
	typedef struct packed {
		logic [7:0] color_index;
		logic       new_color;
		logic       overflow;
		logic       end_of_image;
		logic [8:0] palette_size;
		logic [3:0] index_width;
	} pix_out_t;

	// scan sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} scan_state_t;

endpackage

### rtl/core/ppi_palette_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppi_palette_ram
// Palette color store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ppi_palette_ram #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [ppi_pkg::COLOR_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [ppi_pkg::COLOR_W-1:0] rd_data
);

	logic [ppi_pkg::COLOR_W-1:0] mem [DEPTH];
	logic [ppi_pkg::COLOR_W-1:0] rd_data_q;

	// store appended colors
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read one entry per cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/ppi_scan_fsm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppi_scan_fsm
// Sequencer: takes a pixel, walks the palette one entry a cycle looking for
// an exact match, then appends on a miss if there is room and builds the result.
// ---------------------------------------------------------------------------
module ppi_scan_fsm #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8,
	parameter int unsigned CNT_W  = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel request
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  ppi_pkg::pix_in_t            pixel,
	// result toward the output register
	output logic                        res_valid,
	input  logic                        res_take,
	output ppi_pkg::pix_out_t           res,
	// palette memory
	output logic                        wr_en,
	output logic [ADDR_W-1:0]           wr_addr,
	output logic [ppi_pkg::COLOR_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [ADDR_W-1:0]           rd_addr,
	input  logic [ppi_pkg::COLOR_W-1:0] rd_data
);

	localparam int unsigned PW = $clog2(CNT_W + 1);

	ppi_pkg::scan_state_t state_q, state_d;

	logic [ppi_pkg::COLOR_W-1:0] color_q;
	logic                        last_q;
	logic [CNT_W-1:0]            count_q;
	logic                        ovf_q;
	logic [CNT_W-1:0]            ptr_q;
	logic                        cmp_valid_s1;
	logic [ADDR_W-1:0]           cmp_addr_s1;
	logic                        hit_q;
	logic [ADDR_W-1:0]           hit_idx_q;

	logic                        accept;
	logic [CNT_W-1:0]            eff_count;
	logic                        eff_ovf;
	logic                        match;
	logic                        issue;
	logic [CNT_W-1:0]            cnt_next;
	logic                        ovf_next;
	logic [CNT_W-1:0]            index;
	logic                        fresh;
	logic [CNT_W-1:0]            size_m1;
	logic [PW-1:0]               prec;

	// count and overflow as seen by a request, after an image start
	assign eff_count = pixel.first_pixel ? '0 : count_q;
	assign eff_ovf   = pixel.first_pixel ? 1'b0 : ovf_q;

	assign match = (state_q == ppi_pkg::ST_SCAN) && cmp_valid_s1 && (rd_data == color_q);
	assign issue = (state_q == ppi_pkg::ST_SCAN) && !match && (ptr_q < count_q);

	assign rd_en   = issue;
	assign rd_addr = ptr_q[ADDR_W-1:0];

	// next state and result
	always_comb begin
		state_d     = state_q;
		accept      = 1'b0;
		pixel_stall = 1'b1;
		res_valid   = 1'b0;
		wr_en       = 1'b0;
		cnt_next    = count_q;
		ovf_next    = ovf_q;
		index       = '0;
		fresh       = 1'b0;
		unique case (state_q)
			ppi_pkg::ST_IDLE: begin
				pixel_stall = 1'b0;
				accept      = pixel_valid;
				if (pixel_valid) begin
					if (eff_ovf || (eff_count == '0)) begin
						state_d = ppi_pkg::ST_RESULT;
					end else begin
						state_d = ppi_pkg::ST_SCAN;
					end
				end
			end
			ppi_pkg::ST_SCAN: begin
				if (match || (!cmp_valid_s1 && (ptr_q == count_q))) begin
					state_d = ppi_pkg::ST_RESULT;
				end
			end
			ppi_pkg::ST_RESULT: begin
				res_valid = 1'b1;
				if (ovf_q) begin
					index = '0;
				end else if (hit_q) begin
					index = CNT_W'(hit_idx_q);
				end else if (count_q < CNT_W'(DEPTH)) begin
					wr_en    = res_take;
					index    = count_q;
					cnt_next = count_q + CNT_W'(1);
					fresh    = 1'b1;
				end else begin
					ovf_next = 1'b1;
				end
				if (res_take) begin
					state_d = ppi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppi_pkg::ST_IDLE;
			end
		endcase
	end

	assign wr_addr = count_q[ADDR_W-1:0];
	assign wr_data = color_q;

	// index precision: bit length of size minus one, zero for size 0 or 1
	assign size_m1 = cnt_next - CNT_W'(1);
	always_comb begin
		prec = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (size_m1[i]) begin
				prec = PW'(i + 1);
			end
		end
		if (cnt_next <= CNT_W'(1)) begin
			prec = '0;
		end
	end

	always_comb begin
		res.color_index  = ovf_next ? 8'd0 : 8'(index);
		res.new_color    = fresh;
		res.overflow     = ovf_next;
		res.end_of_image = last_q;
		res.palette_size = 9'(cnt_next);
		res.index_width  = last_q ? 4'(prec) : 4'd0;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// palette fill count and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			count_q <= eff_count;
			ovf_q   <= eff_ovf;
		end else if (res_valid && res_take) begin
			count_q <= cnt_next;
			ovf_q   <= ovf_next;
		end
	end

	// scan pointer and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			hit_q        <= 1'b0;
		end else begin
			cmp_valid_s1 <= issue;
			if (accept) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (issue) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// hold request payload and match position
	always_ff @(posedge clk) begin
		if (accept) begin
			color_q <= {pixel.red, pixel.green, pixel.blue};
			last_q  <= pixel.last_pixel;
		end
		if (issue) begin
			cmp_addr_s1 <= ptr_q[ADDR_W-1:0];
		end
		if (match) begin
			hit_idx_q <= cmp_addr_s1;
		end
	end

endmodule

### rtl/core/pixel_palette_indexer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_palette_indexer_core
// Exact color palette builder: maps each RGB pixel to its first-seen palette
// index, appending new colors and flagging a sticky overflow when full.
//
//  channel  | signals                             | payload
//  ---------+-------------------------------------+-------------------
//  pixel    | pixel_valid, pixel_stall, pixel     | ppi_pkg::pix_in_t
//  result   | result_valid, result_stall, result  | ppi_pkg::pix_out_t
//
// A request scans the palette entries in order until a match, or all of them on
// a miss; the palette memory is read one entry per cycle with registered read
// data, and each read is checked in the compare stage. After an overflow, or
// with an empty palette, a request skips the scan and goes straight to the
// result state. Reset clears the palette count and overflow; the memory needs
// no clearing pass. A request is taken while the previous result still waits
// in the output register; a stalled result holds the next one in the sequencer.
// ---------------------------------------------------------------------------
module pixel_palette_indexer_core #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  ppi_pkg::pix_in_t  pixel,
	output logic              result_valid,
	input  logic              result_stall,
	output ppi_pkg::pix_out_t result
);

	localparam int unsigned ADDR_W = $clog2(PALETTE_DEPTH);
	localparam int unsigned CNT_W  = $clog2(PALETTE_DEPTH + 1);

	logic                        res_valid;
	logic                        res_take;
	ppi_pkg::pix_out_t           res;
	logic                        wr_en;
	logic [ADDR_W-1:0]           wr_addr;
	logic [ppi_pkg::COLOR_W-1:0] wr_data;
	logic                        rd_en;
	logic [ADDR_W-1:0]           rd_addr;
	logic [ppi_pkg::COLOR_W-1:0] rd_data;
	logic                        out_valid_q;
	ppi_pkg::pix_out_t           out_q;

	ppi_scan_fsm #(
		.DEPTH  (PALETTE_DEPTH),
		.ADDR_W (ADDR_W),
		.CNT_W  (CNT_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	ppi_palette_ram #(
		.DEPTH  (PALETTE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// load the output register when it is empty or being drained
	assign res_take = res_valid && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
